[src/dqnb_pkg.sv]
// ----------------------------------------------------------------------------
// dqnb_pkg
// Shared types and constants for the DNS query name blocklist match unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dqnb_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int NAME_BYTES_DEF  = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam int COUNT_W = 11;
    localparam int POS_W   = 11;

    localparam logic [POS_W-1:0] POS_MAX      = 11'd2047;
    localparam logic [POS_W-1:0] FLAGS_HI_POS = 11'd2;
    localparam logic [POS_W-1:0] FLAGS_LO_POS = 11'd3;
    localparam logic [POS_W-1:0] LEN_POS      = 11'd12;
    localparam logic [POS_W-1:0] NAME_START   = 11'd13;

    localparam logic [7:0]  LABEL_DOT     = 8'h2E;
    localparam logic [15:0] BLOCKED_FLAGS = 16'h5153;

    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_PACKET_BYTE = 1'b1;

    typedef enum logic [1:0] {
        NS_COLLECT = 2'd0,
        NS_DONE    = 2'd1,
        NS_ERROR   = 2'd2
    } t_name_state;

    typedef enum logic [1:0] {
        BS_CLEAR = 2'd0,
        BS_IDLE  = 2'd1,
        BS_SCAN  = 2'd2,
        BS_EMIT  = 2'd3
    } t_back_state;

    typedef enum logic {
        JK_WRITE = 1'b0,
        JK_MATCH = 1'b1
    } t_job_kind;

    typedef struct packed {
        logic       op;
        logic [9:0] entry_index;
        logic [4:0] byte_index;
        logic [7:0] value;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        blocked;
        logic        name_error;
        logic [15:0] flags_word;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

[src/dns_query_name_blocklist_match_unit.sv]
// ----------------------------------------------------------------------------
// dns_query_name_blocklist_match_unit
// Packet bytes and table writes are taken one per cycle while busy is low.
// For a last packet byte the back end scans the first min(count, TABLE_DEPTH) entries,
// stopping early on a match and skipping the scan for a bad name; intake stalls
// while the two-deep job queue is full. Results are one-cycle strobes with no stall.
// After reset a clearing pass of the whole table keeps busy high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dns_query_name_blocklist_match_unit #(
    parameter int TABLE_DEPTH = dqnb_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = dqnb_pkg::NAME_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire dqnb_pkg::t_in_item           i_item,
    output dqnb_pkg::t_out_item               o_result,
    output logic                              o_result_valid,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [dqnb_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BI_W   = $clog2(NAME_BYTES);
    localparam int JOB_W  = 1 + 1 + 16 + ADDR_W + BI_W + 8 + 8 * NAME_BYTES;

    logic [dqnb_pkg::COUNT_W-1:0] r_count;
    logic                         w_accept;
    logic                         w_push;
    logic                         w_pop;
    logic                         w_clearing;
    logic [JOB_W-1:0]             w_job_in;
    logic [JOB_W-1:0]             w_job_out;
    dqnb_pkg::t_queue_status      w_qstat;

    assign busy        = w_qstat.full || w_clearing;
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    dqnb_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES),
        .JOB_W       (JOB_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    dqnb_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job_in),
        .i_pop    (w_pop),
        .o_job    (w_job_out),
        .o_status (w_qstat)
    );

    dqnb_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES),
        .JOB_W       (JOB_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_job_out),
        .i_empty        (w_qstat.empty),
        .i_count        (r_count),
        .o_pop          (w_pop),
        .o_clearing     (w_clearing),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // the queue is never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full))
        else $error("job pushed into a full queue");

    // the table clearing pass holds off intake right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("intake open during table clearing");

    // result strobes are single cycles
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // a name in error is never blocked
    a_error_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.name_error |-> !o_result.blocked)
        else $error("blocked verdict on a bad name");

endmodule

`default_nettype wire

[src/dqnb_front.sv]
// ----------------------------------------------------------------------------
// dqnb_front
// Takes items, rebuilds the query name from packet bytes and queues table
// writes and match jobs for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqnb_front #(
    parameter int TABLE_DEPTH = dqnb_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = dqnb_pkg::NAME_BYTES_DEF,
    parameter int JOB_W       = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire dqnb_pkg::t_in_item i_item,
    output logic                    o_push,
    output logic [JOB_W-1:0]        o_job
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BI_W   = $clog2(NAME_BYTES);
    localparam int LEN_W  = $clog2(NAME_BYTES + 1);

    typedef struct packed {
        dqnb_pkg::t_job_kind         kind;
        logic                        name_error;
        logic [15:0]                 flags;
        logic [ADDR_W-1:0]           entry;
        logic [BI_W-1:0]             byte_sel;
        logic [7:0]                  data;
        logic [NAME_BYTES-1:0][7:0]  name;
    } t_job;

    logic [dqnb_pkg::POS_W-1:0] r_pos, n_pos;
    dqnb_pkg::t_name_state      r_state, n_state;
    logic [7:0]                 r_label, n_label;
    logic [LEN_W-1:0]           r_len, n_len;
    logic [NAME_BYTES-1:0][7:0] r_name, n_name;
    logic [15:0]                r_flags, n_flags;
    logic [7:0]                 w_ch;
    logic                       w_pkt;
    logic                       w_wr_ok;
    t_job                       w_job;

    assign w_pkt   = i_accept && (i_item.op == dqnb_pkg::OP_PACKET_BYTE);
    assign w_wr_ok = (32'(i_item.entry_index) < TABLE_DEPTH)
                  && (32'(i_item.byte_index) < NAME_BYTES);

    // name rebuild for one packet byte
    always_comb begin
        n_pos   = r_pos;
        n_state = r_state;
        n_label = r_label;
        n_len   = r_len;
        n_name  = r_name;
        n_flags = r_flags;
        w_ch    = i_item.value;
        if (w_pkt) begin
            if (r_pos == dqnb_pkg::FLAGS_HI_POS) begin
                n_flags[15:8] = i_item.value;
            end else if (r_pos == dqnb_pkg::FLAGS_LO_POS) begin
                n_flags[7:0] = i_item.value;
            end
            if (r_state == dqnb_pkg::NS_COLLECT) begin
                if (r_pos == dqnb_pkg::LEN_POS) begin
                    if (i_item.value == 8'd0) begin
                        n_state = dqnb_pkg::NS_DONE;
                    end else begin
                        n_label = i_item.value;
                    end
                end else if (r_pos >= dqnb_pkg::NAME_START) begin
                    if (i_item.value == 8'd0) begin
                        n_state = dqnb_pkg::NS_DONE;
                    end else begin
                        // any length byte between labels reads as a dot
                        if (r_label == 8'd0) begin
                            w_ch    = dqnb_pkg::LABEL_DOT;
                            n_label = i_item.value;
                        end else begin
                            n_label = r_label - 8'd1;
                        end
                        if (r_len >= LEN_W'(NAME_BYTES)) begin
                            n_state = dqnb_pkg::NS_ERROR;
                        end else begin
                            n_name[r_len[BI_W-1:0]] = w_ch;
                            n_len = r_len + LEN_W'(1);
                        end
                    end
                end
            end
            if (r_pos != dqnb_pkg::POS_MAX) begin
                n_pos = r_pos + dqnb_pkg::POS_W'(1);
            end
        end
    end

    // job toward the back end
    always_comb begin
        w_job          = '0;
        w_job.kind     = dqnb_pkg::JK_WRITE;
        w_job.entry    = ADDR_W'(i_item.entry_index);
        w_job.byte_sel = BI_W'(i_item.byte_index);
        w_job.data     = i_item.value;
        o_push         = 1'b0;
        if (w_pkt && i_item.last) begin
            w_job.kind       = dqnb_pkg::JK_MATCH;
            w_job.name_error = (n_state != dqnb_pkg::NS_DONE);
            w_job.flags      = n_flags;
            w_job.name       = n_name;
            o_push           = 1'b1;
        end else if (i_accept && (i_item.op == dqnb_pkg::OP_TABLE_WRITE) && w_wr_ok) begin
            o_push = 1'b1;
        end
    end

    assign o_job = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_pkt && i_item.last)) begin
            r_pos   <= '0;
            r_state <= dqnb_pkg::NS_COLLECT;
            r_label <= '0;
            r_len   <= '0;
            r_name  <= '0;
            r_flags <= '0;
        end else begin
            r_pos   <= n_pos;
            r_state <= n_state;
            r_label <= n_label;
            r_len   <= n_len;
            r_name  <= n_name;
            r_flags <= n_flags;
        end
    end

endmodule

`default_nettype wire

[src/dqnb_queue.sv]
// ----------------------------------------------------------------------------
// dqnb_queue
// Short job queue between the front end and the table back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqnb_queue #(
    parameter int JOB_W = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire logic [JOB_W-1:0]        i_job,
    input  wire logic                    i_pop,
    output logic [JOB_W-1:0]             o_job,
    output dqnb_pkg::t_queue_status      o_status
);

    localparam int PTR_W = $clog2(dqnb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dqnb_pkg::QUEUE_DEPTH + 1);

    logic [JOB_W-1:0] r_slot [dqnb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    assign o_status.full  = (r_cnt == CNT_W'(dqnb_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_job          = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(dqnb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(dqnb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/dqnb_back.sv]
// ----------------------------------------------------------------------------
// dqnb_back
// Blocklist table memory: clearing pass, byte writes and the entry scan
// that produces the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqnb_back #(
    parameter int TABLE_DEPTH = dqnb_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = dqnb_pkg::NAME_BYTES_DEF,
    parameter int JOB_W       = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [JOB_W-1:0]                 i_job,
    input  wire logic                             i_empty,
    input  wire logic [dqnb_pkg::COUNT_W-1:0]     i_count,
    output logic                                  o_pop,
    output logic                                  o_clearing,
    output dqnb_pkg::t_out_item                   o_result,
    output logic                                  o_result_valid
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BI_W   = $clog2(NAME_BYTES);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > dqnb_pkg::COUNT_W) ? CNT_W : dqnb_pkg::COUNT_W;

    typedef struct packed {
        dqnb_pkg::t_job_kind         kind;
        logic                        name_error;
        logic [15:0]                 flags;
        logic [ADDR_W-1:0]           entry;
        logic [BI_W-1:0]             byte_sel;
        logic [7:0]                  data;
        logic [NAME_BYTES-1:0][7:0]  name;
    } t_job;

    logic [NAME_BYTES-1:0][7:0] r_table [TABLE_DEPTH];
    logic [NAME_BYTES-1:0][7:0] r_rd_row;
    logic [NAME_BYTES-1:0][7:0] r_name;
    logic [15:0]                r_flags;
    logic                       r_err;
    logic                       r_hit;
    logic                       r_pend;
    logic [CNT_W-1:0]           r_addr;
    dqnb_pkg::t_back_state      r_state, n_state;
    dqnb_pkg::t_out_item        r_result;
    logic                       r_result_valid;

    t_job             w_job;
    logic [CMP_W-1:0] w_lim;
    logic             w_clear_last;
    logic             w_clear_we;
    logic             w_byte_we;
    logic             w_take_match;
    logic             w_issue;
    logic             w_emit;

    assign w_job        = t_job'(i_job);
    assign w_lim        = (CMP_W'(i_count) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
                                                                  : CMP_W'(i_count);
    assign w_clear_last = (r_addr[ADDR_W-1:0] == ADDR_W'(TABLE_DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dqnb_pkg::BS_CLEAR: begin
                if (w_clear_last) begin
                    n_state = dqnb_pkg::BS_IDLE;
                end
            end
            dqnb_pkg::BS_IDLE: begin
                if (!i_empty && (w_job.kind == dqnb_pkg::JK_MATCH)) begin
                    n_state = w_job.name_error ? dqnb_pkg::BS_EMIT : dqnb_pkg::BS_SCAN;
                end
            end
            dqnb_pkg::BS_SCAN: begin
                if (!w_issue && !r_pend) begin
                    n_state = dqnb_pkg::BS_EMIT;
                end
            end
            dqnb_pkg::BS_EMIT: begin
                n_state = dqnb_pkg::BS_IDLE;
            end
            default: begin
                n_state = dqnb_pkg::BS_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_clear_we   = 1'b0;
        w_byte_we    = 1'b0;
        w_take_match = 1'b0;
        w_issue      = 1'b0;
        w_emit       = 1'b0;
        o_pop        = 1'b0;
        case (r_state)
            dqnb_pkg::BS_CLEAR: begin
                w_clear_we = 1'b1;
            end
            dqnb_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    o_pop        = 1'b1;
                    w_byte_we    = (w_job.kind == dqnb_pkg::JK_WRITE);
                    w_take_match = (w_job.kind == dqnb_pkg::JK_MATCH);
                end
            end
            dqnb_pkg::BS_SCAN: begin
                // stop issuing reads once a match is seen
                w_issue = (CMP_W'(r_addr) < w_lim) && !r_hit;
            end
            dqnb_pkg::BS_EMIT: begin
                w_emit = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    assign o_clearing = (r_state == dqnb_pkg::BS_CLEAR);

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_clear_we) begin
            r_table[r_addr[ADDR_W-1:0]] <= '0;
        end else if (w_byte_we) begin
            r_table[w_job.entry][w_job.byte_sel] <= w_job.data;
        end
        r_rd_row <= r_table[r_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_take_match) begin
            r_name  <= w_job.name;
            r_flags <= w_job.flags;
            r_err   <= w_job.name_error;
        end
        if (w_emit) begin
            r_result.blocked    <= !r_err && r_hit;
            r_result.name_error <= r_err;
            r_result.flags_word <= (!r_err && r_hit) ? dqnb_pkg::BLOCKED_FLAGS : r_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= dqnb_pkg::BS_CLEAR;
            r_addr         <= '0;
            r_pend         <= 1'b0;
            r_hit          <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pend         <= w_issue;
            r_result_valid <= w_emit;
            if (w_clear_we) begin
                r_addr <= w_clear_last ? '0 : r_addr + CNT_W'(1);
            end else if (w_take_match) begin
                r_addr <= '0;
            end else if (w_issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (w_take_match) begin
                r_hit <= 1'b0;
            end else if (r_pend && (r_rd_row == r_name)) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

endmodule

`default_nettype wire

[verif/dns_query_name_blocklist_match_unit_tb.sv]
// ----------------------------------------------------------------------------
// dns_query_name_blocklist_match_unit_tb
// Drives blocklist byte writes and DNS query packets into the match unit and
// checks each verdict against a cycle-free predictor of the name rebuild and
// the table search. Packets are mostly well-formed queries with random names,
// some taken from the table; the rest are cut, overlong or noise packets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_query_name_blocklist_match_unit_tb;

    localparam int TD          = dqnb_pkg::TABLE_DEPTH_DEF;
    localparam int NB          = dqnb_pkg::NAME_BYTES_DEF;
    localparam int POOL_N      = 6;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASE_PKTS  = 4;

    typedef enum int {
        QK_POOL,
        QK_FRESH,
        QK_BROKEN,
        QK_NOISE
    } t_query_kind;

    // predicts verdicts from accepted items and checks the block's results
    class blocklist_verdict_board;
        bit [NB*8-1:0]              entry_text [TD];
        bit [NB*8-1:0]              name_text;
        logic [dqnb_pkg::POS_W-1:0] pkt_pos;
        int unsigned                name_len;
        int unsigned                label_left;
        int unsigned                active_count;
        dqnb_pkg::t_name_state      nstate;
        logic [15:0]                hdr_flags;
        dqnb_pkg::t_out_item        verdicts [$];
        int                         errors;

        function new();
            foreach (entry_text[i]) entry_text[i] = '0;
            active_count = 0;
            errors = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            name_text  = '0;
            pkt_pos    = '0;
            name_len   = 0;
            label_left = 0;
            nstate     = dqnb_pkg::NS_COLLECT;
            hdr_flags  = '0;
        endfunction

        function void set_count(int unsigned c);
            active_count = c;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function bit name_listed();
            int unsigned n;
            n = (active_count > TD) ? TD : active_count;
            for (int unsigned i = 0; i < n; i++) begin
                if (entry_text[i] == name_text) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(dqnb_pkg::t_in_item it);
            logic [7:0]          ch;
            dqnb_pkg::t_out_item want;
            if (it.op == dqnb_pkg::OP_TABLE_WRITE) begin
                entry_text[it.entry_index][it.byte_index*8 +: 8] = it.value;
                return;
            end
            if (pkt_pos == dqnb_pkg::FLAGS_HI_POS) hdr_flags[15:8] = it.value;
            else if (pkt_pos == dqnb_pkg::FLAGS_LO_POS) hdr_flags[7:0] = it.value;
            if (nstate == dqnb_pkg::NS_COLLECT) begin
                if (pkt_pos == dqnb_pkg::LEN_POS) begin
                    if (it.value == 8'h00) nstate = dqnb_pkg::NS_DONE;
                    else label_left = it.value;
                end else if (pkt_pos >= dqnb_pkg::NAME_START) begin
                    if (it.value == 8'h00) begin
                        nstate = dqnb_pkg::NS_DONE;
                    end else begin
                        // any non-zero byte at a label boundary becomes a dot
                        if (label_left == 0) begin
                            ch = dqnb_pkg::LABEL_DOT;
                            label_left = it.value;
                        end else begin
                            ch = it.value;
                            label_left--;
                        end
                        if (name_len >= NB) begin
                            nstate = dqnb_pkg::NS_ERROR;
                        end else begin
                            name_text[name_len*8 +: 8] = ch;
                            name_len++;
                        end
                    end
                end
            end
            if (pkt_pos < dqnb_pkg::POS_MAX) pkt_pos++;
            if (!it.last) return;
            want.name_error = (nstate != dqnb_pkg::NS_DONE);
            want.blocked    = !want.name_error && name_listed();
            want.flags_word = want.blocked ? dqnb_pkg::BLOCKED_FLAGS : hdr_flags;
            verdicts.push_back(want);
            clear_packet();
        endfunction

        function void check_result(dqnb_pkg::t_out_item got);
            dqnb_pkg::t_out_item want;
            if (verdicts.size() == 0) begin
                $error("result with none expected: blocked %0d name_error %0d flags_word %h",
                       got.blocked, got.name_error, got.flags_word);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (got.blocked !== want.blocked) begin
                $error("blocked: expected %0d actual %0d", want.blocked, got.blocked);
                errors++;
            end
            if (got.name_error !== want.name_error) begin
                $error("name_error: expected %0d actual %0d", want.name_error, got.name_error);
                errors++;
            end
            if (got.flags_word !== want.flags_word) begin
                $error("flags_word: expected %h actual %h", want.flags_word, got.flags_word);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    dqnb_pkg::t_in_item           i_item = '0;
    dqnb_pkg::t_out_item          o_result;
    logic                         o_result_valid;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [dqnb_pkg::COUNT_W-1:0] i_cfg_data = '0;

    blocklist_verdict_board sb = new();

    int          items_sent = 0;
    int          pkts_sent = 0;
    int          gap_next = 0;
    int          quiet_left = 0;
    int unsigned cur_count = 0;
    bit          entry_dirty [TD];
    bit [7:0]    pool_wire [POOL_N][$];
    int          pool_used = 0;
    int          pool_next = 0;

    dns_query_name_blocklist_match_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) sb.check_result(o_result);
    end

    // random gaps with occasional back-to-back stretches
    function automatic int next_gap();
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(10, 60);
        return $urandom_range(0, 17);
    endfunction

    function automatic int scan_cycles();
        return (cur_count > TD) ? TD : cur_count;
    endfunction

    task automatic send_item(input dqnb_pkg::t_in_item it);
        repeat (gap_next) @(posedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(it);
        items_sent++;
        gap_next = next_gap();
        // start stays high when the next item follows at once
        if (gap_next != 0) start <= 1'b0;
    endtask

    task automatic drop_start();
        if (gap_next == 0) begin
            start <= 1'b0;
            gap_next = 1;
        end
    endtask

    task automatic send_table_byte(input int e, input int b, input bit [7:0] v);
        dqnb_pkg::t_in_item it;
        it.op          = dqnb_pkg::OP_TABLE_WRITE;
        it.entry_index = 10'(e);
        it.byte_index  = 5'(b);
        it.value       = v;
        it.last        = 1'($urandom_range(0, 1));
        entry_dirty[e] = 1'b1;
        send_item(it);
    endtask

    task automatic send_packet_byte(input bit [7:0] v, input bit lst);
        dqnb_pkg::t_in_item it;
        it.op          = dqnb_pkg::OP_PACKET_BYTE;
        it.entry_index = 10'($urandom_range(0, TD - 1));
        it.byte_index  = 5'($urandom_range(0, NB - 1));
        it.value       = v;
        it.last        = lst;
        send_item(it);
    endtask

    // drain results, let a pending scan finish, then write the entry count
    task automatic write_count(input int unsigned c);
        drop_start();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (scan_cycles() + 16) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c[dqnb_pkg::COUNT_W-1:0];
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_count(c);
        cur_count = c;
        i_cfg_valid <= 1'b0;
    endtask

    // wire-format name whose dotted form is goal bytes long
    task automatic make_name(input int goal, output bit [7:0] wq[$],
                             output bit [NB*8-1:0] txt);
        int       nlab;
        int       cap;
        int       spare;
        int       k;
        int       tp;
        int       lens[$];
        bit [7:0] ch;
        wq = {};
        txt = '0;
        lens = {};
        cap = goal / 4;
        if (cap > 5) cap = 5;
        if (cap < 1) cap = 1;
        nlab = $urandom_range(1, cap);
        if (goal - (nlab - 1) < nlab) nlab = 1;
        spare = goal - (nlab - 1) - nlab;
        repeat (nlab) lens.push_back(1);
        repeat (spare) begin
            k = $urandom_range(0, nlab - 1);
            lens[k]++;
        end
        tp = 0;
        foreach (lens[li]) begin
            wq.push_back(8'(lens[li]));
            if (li > 0) begin
                if (tp < NB) txt[tp*8 +: 8] = dqnb_pkg::LABEL_DOT;
                tp++;
            end
            repeat (lens[li]) begin
                if ($urandom_range(0, 3) != 0) ch = 8'h61 + 8'($urandom_range(0, 25));
                else ch = 8'($urandom_range(1, 255));
                wq.push_back(ch);
                if (tp < NB) txt[tp*8 +: 8] = ch;
                tp++;
            end
        end
    endtask

    function automatic int fresh_goal();
        case ($urandom_range(0, 9))
            0: return $urandom_range(NB - 1, NB + 1);
            1: return $urandom_range(NB + 2, 50);
            default: return $urandom_range(1, NB - 2);
        endcase
    endfunction

    // put a new name into the table, mostly within the active entries
    task automatic add_pool_name();
        bit [7:0]      wq[$];
        bit [NB*8-1:0] txt;
        int            goal;
        int            lim;
        int            idx;
        int            n;
        goal = ($urandom_range(0, 5) == 0) ? NB : $urandom_range(1, 24);
        make_name(goal, wq, txt);
        lim = scan_cycles();
        if ($urandom_range(0, 7) == 0) idx = TD - 1;
        else if (lim > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, lim - 1);
        else idx = $urandom_range(0, TD - 1);
        n = entry_dirty[idx] ? NB : goal;
        for (int b = 0; b < n; b++) send_table_byte(idx, b, txt[b*8 +: 8]);
        pool_wire[pool_next] = wq;
        pool_wire[pool_next].push_back(8'h00);
        pool_next = (pool_next + 1) % POOL_N;
        if (pool_used < POOL_N) pool_used++;
    endtask

    task automatic send_query(input t_query_kind kind);
        bit [7:0]      pkt[$];
        bit [7:0]      wq[$];
        bit [NB*8-1:0] txt;
        int            slot;
        int            cut;
        int            variant;
        bit            add_tail;
        pkt = {};
        add_tail = 1'b1;
        repeat (12) pkt.push_back(8'($urandom_range(0, 255)));
        if (kind == QK_POOL && pool_used == 0) kind = QK_FRESH;
        case (kind)
            QK_POOL: begin
                slot = $urandom_range(0, pool_used - 1);
                wq = pool_wire[slot];
                pkt = {pkt, wq};
            end
            QK_FRESH: begin
                make_name(fresh_goal(), wq, txt);
                pkt = {pkt, wq};
                pkt.push_back(8'h00);
            end
            QK_BROKEN: begin
                variant = $urandom_range(0, 2);
                if (variant == 0) begin
                    // packet ends inside the header
                    pkt = pkt[0:$urandom_range(0, 11)];
                    add_tail = 1'b0;
                end else begin
                    make_name(fresh_goal(), wq, txt);
                    cut = $urandom_range(0, wq.size() - 1);
                    pkt = {pkt, wq[0:cut]};
                    // early zero, possibly inside a label
                    if (variant == 2) pkt.push_back(8'h00);
                    else add_tail = 1'b0;
                end
            end
            default: begin
                repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if (add_tail) repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(0, 255)));
        foreach (pkt[i]) begin
            // table writes may fall between the bytes of a packet
            if ($urandom_range(0, 15) == 0) begin
                send_table_byte($urandom_range(0, TD - 1), $urandom_range(0, NB - 1),
                                8'($urandom_range(0, 255)));
            end
            send_packet_byte(pkt[i], i == pkt.size() - 1);
        end
        pkts_sent++;
    endtask

    function automatic t_query_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return QK_POOL;
        if (r < 70) return QK_FRESH;
        if (r < 88) return QK_BROKEN;
        return QK_NOISE;
    endfunction

    initial begin
        int unsigned phase_count [7];
        int          item_mark;
        int          pkt_mark;
        phase_count = '{0, 1, 5, TD, 3, 2047, 0};
        phase_count[6] = $urandom_range(6, 60);
        foreach (entry_dirty[i]) entry_dirty[i] = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one active entry, still all zero: the root name matches it
        write_count(1);
        send_table_byte(TD - 1, NB - 1, 8'hFF);
        send_table_byte(TD - 1, NB - 1, 8'h00);
        send_table_byte(0, 0, 8'h00);
        // one-byte packet: unterminated, flags never arrived
        send_packet_byte(8'hFF, 1'b1);
        // packet ending in the header
        send_packet_byte(8'h00, 1'b0);
        send_packet_byte(8'h00, 1'b0);
        send_packet_byte(8'hFF, 1'b0);
        send_packet_byte(8'hFF, 1'b1);
        // root query
        for (int i = 0; i < 12; i++) begin
            if (i == 2) send_packet_byte(8'h12, 1'b0);
            else if (i == 3) send_packet_byte(8'h34, 1'b0);
            else send_packet_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        send_packet_byte(8'h00, 1'b1);

        foreach (phase_count[ph]) begin
            write_count(phase_count[ph]);
            add_pool_name();
            add_pool_name();
            item_mark = items_sent + PHASE_ITEMS;
            pkt_mark = pkts_sent + PHASE_PKTS;
            while (items_sent < item_mark || pkts_sent < pkt_mark) begin
                if ($urandom_range(0, 19) == 0) add_pool_name();
                else send_query(pick_kind());
            end
        end

        drop_start();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (scan_cycles() + 16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
